### src/assert_macros.svh
// assertion macros used by the checker file u8d_checker
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define U8D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define U8D_NEVER(lbl, clk, rst_n, cond, msg) \
  `U8D_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### src/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
// used by u8d_step, utf8_stream_decoder and u8d_checker; no dependencies
package u8d_pkg;

  localparam int ByteW  = 8;
  localparam int CpW    = 31;
  localparam int CountW = 3;
  localparam int ContW  = 6;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [CpW-1:0]    cp_t;
  typedef logic [CountW-1:0] count_t;

  // payload masks kept from each kind of lead byte
  localparam byte_t MaskTwo   = 8'h1F;
  localparam byte_t MaskThree = 8'h0F;
  localparam byte_t MaskFour  = 8'h07;
  localparam byte_t MaskFive  = 8'h03;
  localparam byte_t MaskSix   = 8'h01;

  // one decode step's outcome
  typedef struct packed {
    logic   emit;
    cp_t    code_point;
    count_t bytes_used;
  } result_t;

endpackage

### src/utf8_stream_decoder.sv
// utf-8 stream decoder: an accepted word is held in the input register, and the result
// of a sequence's last word is registered on out_*; throughput one word per cycle while
// out_ready does not stall it, set by the single input-register to result-register pass through u8d_step
// synchronous active-low reset clears the input and result valids and the
// sequence state (decoder waits for a lead word); depends on u8d_pkg, u8d_step
module utf8_stream_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8d_pkg::byte_t      in_byte_in,
  output logic                out_valid,
  input  logic                out_ready,
  output u8d_pkg::cp_t        out_code_point,
  output u8d_pkg::count_t     out_bytes_used
);

  logic              in_vld_r;
  u8d_pkg::byte_t    byte_r;
  logic              out_vld_r;
  u8d_pkg::cp_t      cp_r;
  u8d_pkg::count_t   used_r;
  logic              out_free;
  logic              step;
  u8d_pkg::result_t  res;

  // a held word moves on whenever the result register can take a result
  assign out_free = !out_vld_r || out_ready;
  assign step     = in_vld_r && out_free;
  assign in_ready = !in_vld_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
  end

  u8d_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_i (byte_r),
    .result (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= res.emit;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      cp_r   <= res.code_point;
      used_r <= res.bytes_used;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = cp_r;
  assign out_bytes_used = used_r;

endmodule

### src/u8d_step.sv
// sequence state and one-word decode step of the utf-8 stream decoder
// depends on u8d_pkg
module u8d_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  u8d_pkg::byte_t    byte_i,
  output u8d_pkg::result_t  result
);

  u8d_pkg::cp_t    pv_r, pv_nxt;
  u8d_pkg::count_t rem_r, rem_nxt;
  u8d_pkg::count_t taken_r, taken_nxt;
  u8d_pkg::cp_t    acc;
  u8d_pkg::count_t taken_inc;

  // continuation merge: six new low bits under the shifted accumulator
  assign acc       = {pv_r[u8d_pkg::CpW-u8d_pkg::ContW-1:0], byte_i[u8d_pkg::ContW-1:0]};
  assign taken_inc = taken_r + u8d_pkg::count_t'(1);

  // next state and result
  always_comb begin
    pv_nxt            = pv_r;
    rem_nxt           = rem_r;
    taken_nxt         = taken_r;
    result.emit       = 1'b0;
    result.code_point = '0;
    result.bytes_used = '0;
    if (step) begin
      if (rem_r != '0) begin
        if (rem_r == u8d_pkg::count_t'(1)) begin
          result.emit       = 1'b1;
          result.code_point = acc;
          result.bytes_used = taken_inc;
          pv_nxt            = '0;
          rem_nxt           = '0;
          taken_nxt         = '0;
        end else begin
          pv_nxt    = acc;
          rem_nxt   = rem_r - u8d_pkg::count_t'(1);
          taken_nxt = taken_inc;
        end
      end else begin
        taken_nxt = u8d_pkg::count_t'(1);
        case (byte_i) inside
          [8'h00:8'h7F]: begin
            result.emit       = 1'b1;
            result.code_point = u8d_pkg::cp_t'(byte_i);
            result.bytes_used = u8d_pkg::count_t'(1);
            taken_nxt         = '0;
          end
          [8'hFE:8'hFF]: begin
            result.emit       = 1'b1;
            result.bytes_used = u8d_pkg::count_t'(1);
            taken_nxt         = '0;
          end
          [8'hFC:8'hFD]: begin
            pv_nxt  = u8d_pkg::cp_t'(byte_i & u8d_pkg::MaskSix);
            rem_nxt = u8d_pkg::count_t'(5);
          end
          [8'hF8:8'hFB]: begin
            pv_nxt  = u8d_pkg::cp_t'(byte_i & u8d_pkg::MaskFive);
            rem_nxt = u8d_pkg::count_t'(4);
          end
          [8'hF0:8'hF7]: begin
            pv_nxt  = u8d_pkg::cp_t'(byte_i & u8d_pkg::MaskFour);
            rem_nxt = u8d_pkg::count_t'(3);
          end
          [8'hE0:8'hEF]: begin
            pv_nxt  = u8d_pkg::cp_t'(byte_i & u8d_pkg::MaskThree);
            rem_nxt = u8d_pkg::count_t'(2);
          end
          [8'hC0:8'hDF]: begin
            pv_nxt  = u8d_pkg::cp_t'(byte_i & u8d_pkg::MaskTwo);
            rem_nxt = u8d_pkg::count_t'(1);
          end
          default: begin
            // stray continuation as lead: kept whole, one more word
            pv_nxt  = u8d_pkg::cp_t'(byte_i);
            rem_nxt = u8d_pkg::count_t'(1);
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      rem_r   <= '0;
      taken_r <= '0;
    end else begin
      pv_r    <= pv_nxt;
      rem_r   <= rem_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

### src/u8d_checker.sv
// port-level checks for the utf-8 stream decoder, bound to the top level
// depends on u8d_pkg and assert_macros.svh
`include "assert_macros.svh"

module u8d_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input u8d_pkg::cp_t     out_code_point,
  input u8d_pkg::count_t  out_bytes_used
);

  // a stalled result holds its word
  `U8D_ASSERT(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=>
      out_valid && $stable(out_code_point) && $stable(out_bytes_used),
    "stalled result changed")

  // sequence length is one to six words
  `U8D_NEVER(a_used_range, clk, rst_n,
    out_valid && (out_bytes_used == 3'd0 || out_bytes_used == 3'd7),
    "bytes_used out of range")

  // single-word results are ascii or zero
  `U8D_ASSERT(a_single_ascii, clk, rst_n,
    out_valid && out_bytes_used == 3'd1 |-> out_code_point < 31'd128,
    "single word result above 7 bits")

  // two-word results fit in 14 bits
  `U8D_ASSERT(a_two_width, clk, rst_n,
    out_valid && out_bytes_used == 3'd2 |-> out_code_point < 31'd16384,
    "two word result above 14 bits")

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_point (out_code_point),
  .out_bytes_used (out_bytes_used)
);
